FILE: src/ght_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes of the generational handle table.
// No dependencies; every other file of the block but ght_ram imports this package.
package ght_pkg;

    // Function codes of an input item.
    localparam logic [2:0] FN_CREATE   = 3'd0;
    localparam logic [2:0] FN_RETAIN   = 3'd1;
    localparam logic [2:0] FN_RELEASE  = 3'd2;
    localparam logic [2:0] FN_VALIDATE = 3'd3;
    localparam logic [2:0] FN_ATTACH   = 3'd4;
    localparam logic [2:0] FN_GET      = 3'd5;

    // Status codes of a result item.
    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_BAD_ARG   = 3'd1;
    localparam logic [2:0] STAT_BAD_TYPE  = 3'd2;
    localparam logic [2:0] STAT_NO_MEM    = 3'd3;
    localparam logic [2:0] STAT_BAD_STATE = 3'd4;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_EN = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIN_EN  = 4'd1;

    localparam logic [31:0] GEN_MAX   = 32'hFFFF_FFFF;
    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    typedef enum logic [0:0] {
        SEQ_IDLE = 1'b0,
        SEQ_EXEC = 1'b1
    } seq_state_t;

    // One slot entry as held in the entry memory.
    typedef struct packed {
        logic        in_use;
        logic [31:0] generation;
        logic [31:0] count;
        logic [63:0] word;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Sequencer controls toward the datapath.
    typedef struct packed {
        logic in_stall;
        logic accept;
        logic commit;
    } ctl_t;

    // State updates that one operation asks for.
    typedef struct packed {
        logic entry_we;
        logic push;
        logic pop;
        logic extend;
    } upd_t;

    // Fields of one result item.
    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] new_slot;
        logic [31:0] new_generation;
        logic        handle_valid;
        logic [63:0] user_value_out;
        logic        finalize_request;
    } res_t;

endpackage

FILE: src/ght_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
module ght_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
)(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/ght_seq.sv
`timescale 1ns / 1ps
// Two-state sequencer of the handle table: accept and read, then commit.
// Depends on ght_pkg.
module ght_seq
    import ght_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic out_busy,
    output ctl_t ctl
);

    seq_state_t state_reg;
    seq_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SEQ_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = SEQ_EXEC;
                end
            end
            SEQ_EXEC:
            begin
                if (!out_busy)
                begin
                    state_next = SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl = '0;
        case (state_reg)
            SEQ_IDLE:
            begin
                ctl.accept = in_valid;
            end
            SEQ_EXEC:
            begin
                ctl.in_stall = 1'b1;
                ctl.commit   = !out_busy;
            end
            default:
            begin
                ctl.in_stall = 1'b1;
            end
        endcase
    end

endmodule

FILE: src/ght_alu.sv
`timescale 1ns / 1ps
// Operation logic: checks a handle against the read entry and forms the
// entry write-back, stack updates and result fields. Depends on ght_pkg.
module ght_alu
    import ght_pkg::*;
#(
    parameter int SLOTS = 256
)(
    input  logic [2:0]                 func,
    input  logic [15:0]                slot,
    input  logic [31:0]                generation,
    input  logic [63:0]                user_value,
    input  entry_t                     rd_entry,
    input  logic [$clog2(SLOTS)-1:0]   top_slot,
    input  logic [$clog2(SLOTS+1)-1:0] free_count,
    input  logic [$clog2(SLOTS+1)-1:0] slots_used,
    input  logic                       type_en,
    input  logic                       fin_en,
    output upd_t                       upd,
    output logic [$clog2(SLOTS)-1:0]   wr_addr,
    output entry_t                     wr_entry,
    output res_t                       res
);

    localparam int IW   = $clog2(SLOTS);
    localparam int CW   = $clog2(SLOTS + 1);
    localparam int CMPW = (CW > 16) ? CW : 16;

    logic live;

    assign live = (CMPW'(slot) < CMPW'(slots_used)) && rd_entry.in_use
                  && (rd_entry.generation == generation);

    always_comb
    begin
        logic [IW-1:0] idx;
        logic [31:0]   gen;
        idx      = top_slot;
        gen      = rd_entry.generation;
        upd      = '0;
        res      = '0;
        wr_entry = rd_entry;
        wr_addr  = slot[IW-1:0];
        case (func)
            FN_CREATE:
            begin
                if (!type_en)
                begin
                    res.status = STAT_BAD_TYPE;
                end
                else if (free_count != '0)
                begin
                    upd.pop = 1'b1;
                end
                else if (slots_used != CW'(SLOTS))
                begin
                    // A slot at or past the high-water mark was never written.
                    upd.extend = 1'b1;
                    idx        = slots_used[IW-1:0];
                    gen        = '0;
                end
                else
                begin
                    res.status = STAT_NO_MEM;
                end
                if (upd.pop || upd.extend)
                begin
                    upd.entry_we        = 1'b1;
                    wr_addr             = idx;
                    wr_entry.in_use     = 1'b1;
                    wr_entry.generation = gen;
                    wr_entry.count      = 32'd1;
                    wr_entry.word       = '0;
                    res.new_slot        = 16'(idx);
                    res.new_generation  = gen;
                end
            end
            FN_RETAIN:
            begin
                if (!live)
                begin
                    res.status = STAT_BAD_ARG;
                end
                else if (rd_entry.count != COUNT_MAX)
                begin
                    upd.entry_we   = 1'b1;
                    wr_entry.count = rd_entry.count + 32'd1;
                end
            end
            FN_RELEASE:
            begin
                if (!live)
                begin
                    res.status = STAT_BAD_ARG;
                end
                else if (rd_entry.count == '0)
                begin
                    res.status = STAT_BAD_STATE;
                end
                else
                begin
                    upd.entry_we   = 1'b1;
                    wr_entry.count = rd_entry.count - 32'd1;
                    if (rd_entry.count == 32'd1)
                    begin
                        res.finalize_request = type_en && fin_en;
                        wr_entry.in_use      = 1'b0;
                        // A slot at the last generation is retired, not recycled.
                        if (rd_entry.generation != GEN_MAX)
                        begin
                            wr_entry.generation = rd_entry.generation + 32'd1;
                            upd.push            = (free_count < CW'(SLOTS));
                        end
                    end
                end
            end
            FN_VALIDATE:
            begin
                res.handle_valid = live;
            end
            FN_ATTACH:
            begin
                if (!live)
                begin
                    res.status = STAT_BAD_ARG;
                end
                else
                begin
                    upd.entry_we  = 1'b1;
                    wr_entry.word = user_value;
                end
            end
            FN_GET:
            begin
                if (!live)
                begin
                    res.status = STAT_BAD_ARG;
                end
                else
                begin
                    res.user_value_out = rd_entry.word;
                end
            end
            default:
            begin
                res.status = STAT_BAD_ARG;
            end
        endcase
    end

endmodule

FILE: src/generational_handle_table_top.sv
`timescale 1ns / 1ps
// Generational handle table, top level. Depends on ght_pkg, ght_ram, ght_seq, ght_alu.
// A result item is loaded into the output register when its item commits, after the entry
// memory read; the commit waits while the previous result item is still held by out_stall.
// Items go one at a time, each read and then written back in the entry memory before the next is accepted.
// Reset: counters and configuration return to their reset values at once; no memory
// clearing pass is run, and items are accepted from the first cycle after reset.
module generational_handle_table_top
    import ght_pkg::*;
#(
    parameter int SLOTS = 256
)(
    input  logic                 clk,
    input  logic                 rst_n,
    // Input channel.
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [2:0]           func,
    input  logic [15:0]          slot,
    input  logic [31:0]          generation,
    input  logic [63:0]          user_value,
    // Result channel.
    output logic                 result_valid,
    input  logic                 out_stall,
    output logic [2:0]           status,
    output logic [15:0]          new_slot,
    output logic [31:0]          new_generation,
    output logic                 handle_valid,
    output logic [63:0]          user_value_out,
    output logic                 finalize_request,
    // Configuration write channel.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic                 cfg_data
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    // The block works on one item at a time. In the accept cycle the entry
    // memory and the free stack are both read; in the EXEC state that follows
    // the operation is evaluated, and when the item commits the entry is
    // written back and the result item is loaded into the output register.
    // The input is stalled while an item is in flight, so a write always
    // lands before the next read and no forwarding is needed.
    //
    // The top of the free stack is kept in a register. On every accept the
    // stack memory is read one place below the top, so a pop can refill
    // the top register from that read in the same commit cycle.
    //
    // The memories are never cleared. The high-water count works as a fill
    // count: a slot at or above it has never been written, so its contents
    // are never trusted, and a slot taken by extending the table starts at
    // generation zero regardless of what the memory holds.

    ctl_t   ctl;
    upd_t   upd;
    res_t   res;
    entry_t rd_entry;
    entry_t wr_entry;

    logic [IW-1:0] wr_addr;
    logic [IW-1:0] entry_raddr;
    logic [IW-1:0] stack_rdata;
    logic [CW-1:0] fc_minus2;

    // Item held while it is evaluated.
    logic [2:0]  func_reg;
    logic [15:0] slot_reg;
    logic [31:0] gen_reg;
    logic [63:0] word_reg;

    logic [CW-1:0] free_count_reg;
    logic [CW-1:0] free_count_next;
    logic [CW-1:0] slots_used_reg;
    logic [CW-1:0] slots_used_next;
    logic [IW-1:0] top_reg;
    logic [IW-1:0] top_next;

    logic type_en_reg;
    logic fin_en_reg;

    logic result_valid_reg;
    logic result_valid_next;
    res_t out_res_reg;

    ght_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_busy (result_valid_reg && out_stall),
        .ctl      (ctl)
    );

    assign in_stall = ctl.in_stall;

    // A create addresses the slot it is about to hand out; everything else
    // addresses the slot named by the handle.
    always_comb
    begin
        if (func == FN_CREATE)
        begin
            entry_raddr = (free_count_reg != '0) ? top_reg : slots_used_reg[IW-1:0];
        end
        else
        begin
            entry_raddr = slot[IW-1:0];
        end
    end

    assign fc_minus2 = free_count_reg - CW'(2);

    ght_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ctl.commit && upd.entry_we),
        .waddr (wr_addr),
        .wdata (wr_entry),
        .re    (ctl.accept),
        .raddr (entry_raddr),
        .rdata (rd_entry)
    );

    ght_ram #(
        .WIDTH (IW),
        .DEPTH (SLOTS)
    ) u_stack_ram (
        .clk   (clk),
        .we    (ctl.commit && upd.push),
        .waddr (free_count_reg[IW-1:0]),
        .wdata (slot_reg[IW-1:0]),
        .re    (ctl.accept),
        .raddr (fc_minus2[IW-1:0]),
        .rdata (stack_rdata)
    );

    ght_alu #(
        .SLOTS (SLOTS)
    ) u_alu (
        .func       (func_reg),
        .slot       (slot_reg),
        .generation (gen_reg),
        .user_value (word_reg),
        .rd_entry   (rd_entry),
        .top_slot   (top_reg),
        .free_count (free_count_reg),
        .slots_used (slots_used_reg),
        .type_en    (type_en_reg),
        .fin_en     (fin_en_reg),
        .upd        (upd),
        .wr_addr    (wr_addr),
        .wr_entry   (wr_entry),
        .res        (res)
    );

    // Stack and high-water bookkeeping, applied when the item commits.
    always_comb
    begin
        free_count_next = free_count_reg;
        slots_used_next = slots_used_reg;
        top_next        = top_reg;
        if (ctl.commit)
        begin
            if (upd.pop)
            begin
                free_count_next = free_count_reg - CW'(1);
                top_next        = stack_rdata;
            end
            if (upd.push)
            begin
                free_count_next = free_count_reg + CW'(1);
                top_next        = slot_reg[IW-1:0];
            end
            if (upd.extend)
            begin
                slots_used_next = slots_used_reg + CW'(1);
            end
        end
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (ctl.commit)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_valid_reg && !out_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_count_reg   <= '0;
            slots_used_reg   <= '0;
            top_reg          <= '0;
            type_en_reg      <= 1'b1;
            fin_en_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            free_count_reg   <= free_count_next;
            slots_used_reg   <= slots_used_next;
            top_reg          <= top_next;
            result_valid_reg <= result_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_TYPE_EN)
                begin
                    type_en_reg <= cfg_data;
                end
                else if (cfg_index == CFG_FIN_EN)
                begin
                    fin_en_reg <= cfg_data;
                end
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            func_reg <= func;
            slot_reg <= slot;
            gen_reg  <= generation;
            word_reg <= user_value;
        end
        if (ctl.commit)
        begin
            out_res_reg <= res;
        end
    end

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    assign result_valid     = result_valid_reg;
    assign status           = out_res_reg.status;
    assign new_slot         = out_res_reg.new_slot;
    assign new_generation   = out_res_reg.new_generation;
    assign handle_valid     = out_res_reg.handle_valid;
    assign user_value_out   = out_res_reg.user_value_out;
    assign finalize_request = out_res_reg.finalize_request;

endmodule

FILE: src/ght_checker.sv
`timescale 1ns / 1ps
// Port-level assertions of the handle table and the bind that attaches them.
// Depends on ght_pkg and generational_handle_table_top.
module ght_checker
    import ght_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic [2:0]           func,
    input logic [15:0]          slot,
    input logic [31:0]          generation,
    input logic [63:0]          user_value,
    input logic                 result_valid,
    input logic                 out_stall,
    input logic [2:0]           status,
    input logic [15:0]          new_slot,
    input logic [31:0]          new_generation,
    input logic                 handle_valid,
    input logic [63:0]          user_value_out,
    input logic                 finalize_request,
    input logic                 cfg_valid,
    input logic                 cfg_ready,
    input logic [CFG_IDX_W-1:0] cfg_index,
    input logic                 cfg_data
);

    // One item at a time: an accepted item blocks the next one.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted while an item was in flight");

    // A fresh result only appears while an item was in flight.
    a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(in_stall))
        else $error("result appeared with no item in flight");

    // A failed operation gives out nothing.
    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status != STAT_OK) |-> (new_slot == '0) && (new_generation == '0)
        && (user_value_out == '0) && !finalize_request && !handle_valid)
        else $error("failed operation returned data");

    // A stalled result is held.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && out_stall |=> result_valid && $stable(status) && $stable(new_slot))
        else $error("stalled result changed");

endmodule

bind generational_handle_table_top ght_checker u_ght_checker (.*);

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the generational handle table (generational_handle_table_top).
// Depends on ght_pkg and the RTL of the block; it predicts every result item internally.
module tb_top;

    import ght_pkg::*;

    localparam int TABLE_SLOTS = 256;

    // Function codes that the block does not define; they must be refused.
    localparam logic [2:0] FN_UNUSED_6 = 3'd6;
    localparam logic [2:0] FN_UNUSED_7 = 3'd7;

    // Clock, reset and all block inputs start at known values.
    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 in_valid   = 1'b0;
    logic [2:0]           func       = FN_CREATE;
    logic [15:0]          slot       = '0;
    logic [31:0]          generation = '0;
    logic [63:0]          user_value = '0;
    logic                 out_stall  = 1'b0;
    logic                 cfg_valid  = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index  = CFG_TYPE_EN;
    logic                 cfg_data   = 1'b0;

    logic        in_stall;
    logic        result_valid;
    logic [2:0]  status;
    logic [15:0] new_slot;
    logic [31:0] new_generation;
    logic        handle_valid;
    logic [63:0] user_value_out;
    logic        finalize_request;
    logic        cfg_ready;

    // Mirror of the handle table, kept in step with every accepted item.
    logic        tbl_live  [TABLE_SLOTS] = '{default: 1'b0};
    logic [31:0] tbl_gen   [TABLE_SLOTS] = '{default: 32'd0};
    logic [31:0] tbl_refs  [TABLE_SLOTS] = '{default: 32'd0};
    logic [63:0] tbl_word  [TABLE_SLOTS] = '{default: 64'd0};
    logic [7:0]  free_slots[TABLE_SLOTS] = '{default: 8'd0};
    int          free_depth = 0;
    int          high_water = 0;
    logic        type_on    = 1'b1;
    logic        fin_on     = 1'b0;

    // Results still owed by the block, oldest first.
    res_t pending_results[$];
    res_t last_prediction;
    int   bad_results = 0;

    // Idle rates of both sides in percent, and the length of a forced receiver hold.
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_left   = 0;

    generational_handle_table_top #(
        .SLOTS(TABLE_SLOTS)
    ) uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .func            (func),
        .slot            (slot),
        .generation      (generation),
        .user_value      (user_value),
        .result_valid    (result_valid),
        .out_stall       (out_stall),
        .status          (status),
        .new_slot        (new_slot),
        .new_generation  (new_generation),
        .handle_valid    (handle_valid),
        .user_value_out  (user_value_out),
        .finalize_request(finalize_request),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #6 clk = ~clk;

    // Works out the result of one operation and applies it to the mirror table.
    function automatic res_t compute_handle_result(input logic [2:0] fn, input logic [15:0] sl,
                                                   input logic [31:0] gn, input logic [63:0] wd);
        res_t r;
        logic live;
        logic granted;
        int   idx;
        int   s;
        r       = '0;
        granted = 1'b0;
        idx     = 0;
        s       = int'(sl) % TABLE_SLOTS;
        live    = (int'(sl) < high_water) && tbl_live[s] && (tbl_gen[s] == gn);
        case (fn)
            FN_CREATE:
            begin
                if (!type_on)
                    r.status = STAT_BAD_TYPE;
                else if (free_depth > 0)
                begin
                    // The most recently freed slot is handed out first.
                    free_depth--;
                    idx     = free_slots[free_depth];
                    granted = 1'b1;
                end
                else if (high_water < TABLE_SLOTS)
                begin
                    idx     = high_water;
                    high_water++;
                    granted = 1'b1;
                end
                else
                    r.status = STAT_NO_MEM;
                if (granted)
                begin
                    tbl_live[idx]    = 1'b1;
                    tbl_refs[idx]    = 32'd1;
                    tbl_word[idx]    = 64'd0;
                    r.new_slot       = idx[15:0];
                    r.new_generation = tbl_gen[idx];
                end
            end
            FN_RETAIN:
            begin
                if (!live)
                    r.status = STAT_BAD_ARG;
                else if (tbl_refs[s] != COUNT_MAX)
                    tbl_refs[s] = tbl_refs[s] + 32'd1;
            end
            FN_RELEASE:
            begin
                if (!live)
                    r.status = STAT_BAD_ARG;
                else if (tbl_refs[s] == 32'd0)
                    r.status = STAT_BAD_STATE;
                else
                begin
                    tbl_refs[s] = tbl_refs[s] - 32'd1;
                    if (tbl_refs[s] == 32'd0)
                    begin
                        // Last reference: free the slot. A slot at the last generation
                        // is retired instead of going back on the free stack.
                        r.finalize_request = type_on && fin_on;
                        tbl_live[s]        = 1'b0;
                        if (tbl_gen[s] != GEN_MAX)
                        begin
                            tbl_gen[s] = tbl_gen[s] + 32'd1;
                            if (free_depth < TABLE_SLOTS)
                            begin
                                free_slots[free_depth] = s[7:0];
                                free_depth++;
                            end
                        end
                    end
                end
            end
            FN_VALIDATE:
                r.handle_valid = live;
            FN_ATTACH:
            begin
                if (!live)
                    r.status = STAT_BAD_ARG;
                else
                    tbl_word[s] = wd;
            end
            FN_GET:
            begin
                if (!live)
                    r.status = STAT_BAD_ARG;
                else
                    r.user_value_out = tbl_word[s];
            end
            default:
                r.status = STAT_BAD_ARG;
        endcase
        return r;
    endfunction

    // Finds a slot that is currently in use, starting at a random point.
    function automatic logic pick_live_slot(output logic [15:0] sl);
        int start;
        int idx;
        start = $urandom_range(0, TABLE_SLOTS - 1);
        sl    = '0;
        for (int k = 0; k < TABLE_SLOTS; k++)
        begin
            idx = (start + k) % TABLE_SLOTS;
            if (idx < high_water && tbl_live[idx])
            begin
                sl = idx[15:0];
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Offers one item, possibly after a random gap, and records its expected result once
    // the block takes it. The task returns at the accepting edge with valid still high, so
    // that the next call can follow back to back without a bubble.
    task automatic send_item(input logic [2:0] fn, input logic [15:0] sl,
                             input logic [31:0] gn, input logic [63:0] wd);
        @(negedge clk);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        func       <= fn;
        slot       <= sl;
        generation <= gn;
        user_value <= wd;
        do
            @(posedge clk);
        while (in_stall);
        last_prediction = compute_handle_result(fn, sl, gn, wd);
        pending_results = {pending_results, last_prediction};
    endtask

    // Drops the input valid and waits until every owed result has come back.
    task automatic settle_table();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_config(input logic [CFG_IDX_W-1:0] idx, input logic val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_TYPE_EN)
            type_on = val;
        else if (idx == CFG_FIN_EN)
            fin_on = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Every function on fresh and stale handles, field extremes and refused codes.
    task automatic test_basic_operations();
        logic [15:0] a_slot;
        logic [31:0] a_gen;
        logic [15:0] b_slot;
        logic [31:0] b_gen;
        send_item(FN_VALIDATE, 16'd0, 32'd0, 64'd0);
        send_item(FN_CREATE, 16'd0, 32'd0, 64'd0);
        a_slot = last_prediction.new_slot;
        a_gen  = last_prediction.new_generation;
        send_item(FN_CREATE, 16'hFFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        b_slot = last_prediction.new_slot;
        b_gen  = last_prediction.new_generation;
        send_item(FN_VALIDATE, a_slot, a_gen, 64'd0);
        send_item(FN_ATTACH, a_slot, a_gen, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(FN_GET, a_slot, a_gen, 64'd0);
        send_item(FN_ATTACH, b_slot, b_gen, 64'h8000_0000_0000_0001);
        send_item(FN_GET, b_slot, b_gen, 64'd0);
        send_item(FN_RETAIN, a_slot, a_gen, 64'd0);
        send_item(FN_RELEASE, a_slot, a_gen, 64'd0);
        // This release drops the last reference; the finalizer is off after reset.
        send_item(FN_RELEASE, a_slot, a_gen, 64'd0);
        send_item(FN_VALIDATE, a_slot, a_gen, 64'd0);
        send_item(FN_GET, a_slot, a_gen, 64'd0);
        send_item(FN_RETAIN, a_slot, a_gen, 64'd0);
        send_item(FN_RELEASE, a_slot, a_gen, 64'd0);
        // The freed slot comes back with a new generation and a cleared word.
        send_item(FN_CREATE, 16'd0, 32'd0, 64'd0);
        a_slot = last_prediction.new_slot;
        a_gen  = last_prediction.new_generation;
        send_item(FN_GET, a_slot, a_gen, 64'd0);
        send_item(FN_RELEASE, b_slot, b_gen + 32'd1, 64'd0);
        send_item(FN_UNUSED_6, b_slot, b_gen, 64'd0);
        send_item(FN_UNUSED_7, 16'hFFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(FN_VALIDATE, 16'hFFFF, 32'hFFFF_FFFF, 64'd0);
        send_item(FN_ATTACH, 16'hFFFF, 32'd0, 64'h5555_AAAA_5555_AAAA);
        send_item(FN_GET, 16'h0100, b_gen, 64'd0);
    endtask

    // Finalize requests with the finalizer on, and create refused with the type disabled.
    task automatic test_type_and_finalize();
        logic [15:0] c_slot;
        logic [31:0] c_gen;
        settle_table();
        write_config(CFG_FIN_EN, 1'b1);
        send_item(FN_CREATE, 16'd0, 32'd0, 64'd0);
        c_slot = last_prediction.new_slot;
        c_gen  = last_prediction.new_generation;
        send_item(FN_RELEASE, c_slot, c_gen, 64'd0);
        send_item(FN_CREATE, 16'd0, 32'd0, 64'd0);
        c_slot = last_prediction.new_slot;
        c_gen  = last_prediction.new_generation;
        settle_table();
        write_config(CFG_TYPE_EN, 1'b0);
        send_item(FN_CREATE, 16'd0, 32'd0, 64'd0);
        // With the type disabled the last release must not ask for a finalizer.
        send_item(FN_RELEASE, c_slot, c_gen, 64'd0);
        send_item(FN_VALIDATE, c_slot, c_gen, 64'd0);
        settle_table();
        write_config(CFG_TYPE_EN, 1'b1);
        write_config(CFG_FIN_EN, 1'b0);
    endtask

    // The receiver holds off for a long stretch while items keep coming, so the block
    // fills up and has to stall its input.
    task automatic test_output_backpressure();
        settle_table();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_left   = 60;
        for (int n = 0; n < 14; n++)
            send_item((n % 3 == 0) ? FN_CREATE : FN_VALIDATE, n[15:0], 32'd0, {$urandom, $urandom});
        settle_table();
    endtask

    // Random items. Apart from the creates set by create_pct, most name a live handle with its true generation;
    // the rest are stale handles, slots out of range, refused function codes and fully random fields.
    task automatic run_random_items(input int count, input int create_pct);
        logic [2:0]  fn;
        logic [15:0] sl;
        logic [31:0] gn;
        logic [63:0] wd;
        int          roll;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 99);
            fn   = FN_CREATE;
            sl   = 16'($urandom);
            gn   = $urandom;
            wd   = {$urandom, $urandom};
            if (roll < create_pct)
                fn = FN_CREATE;
            else if (roll < 88)
            begin
                if (pick_live_slot(sl))
                begin
                    fn = 3'($urandom_range(FN_RETAIN, FN_GET));
                    gn = tbl_gen[sl[7:0]];
                end
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0: fn = 3'($urandom_range(0, 7));
                    1:
                    begin
                        fn = 3'($urandom_range(FN_RETAIN, FN_GET));
                        if (high_water > 0)
                        begin
                            sl = 16'($urandom_range(0, high_water - 1));
                            gn = tbl_gen[sl[7:0]] + ($urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF);
                        end
                    end
                    2: fn = 3'($urandom_range(FN_UNUSED_6, FN_UNUSED_7));
                    default:
                    begin
                        // Current generation of any slot in range, live or freed.
                        fn = 3'($urandom_range(FN_RETAIN, FN_GET));
                        if (high_water > 0)
                        begin
                            sl = 16'($urandom_range(0, high_water - 1));
                            gn = tbl_gen[sl[7:0]];
                        end
                    end
                endcase
            end
            send_item(fn, sl, gn, wd);
        end
    endtask

    // Three idle patterns with the configuration moved between them. The first phase is
    // heavy on create, so the table runs full and create reports out of memory.
    task automatic test_random_traffic();
        settle_table();
        tx_idle_pct = 16;
        rx_idle_pct = 51;
        write_config(CFG_FIN_EN, 1'b1);
        run_random_items(600, 60);

        settle_table();
        tx_idle_pct = 51;
        rx_idle_pct = 16;
        write_config(CFG_TYPE_EN, 1'b0);
        write_config(CFG_FIN_EN, 1'b0);
        run_random_items(200, 25);
        settle_table();
        write_config(CFG_TYPE_EN, 1'b1);
        write_config(CFG_FIN_EN, 1'b1);
        run_random_items(400, 15);

        settle_table();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_config(CFG_FIN_EN, 1'b0);
        run_random_items(550, 20);
    endtask

    // Receiver side: a forced hold wins over the random stall.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end

    // Each accepted result is held against the oldest expectation.
    always @(posedge clk)
    begin : result_check
        res_t seen;
        res_t want;
        if (rst_n && result_valid && !out_stall)
        begin
            seen = {status, new_slot, new_generation, handle_valid, user_value_out,
                    finalize_request};
            if (pending_results.size() == 0)
            begin
                if (bad_results < 10)
                    $display("Unexpected result item at %0t: status=%0d", $realtime, status);
                bad_results++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (seen !== want)
                begin
                    if (bad_results < 10)
                    begin
                        $display("Mismatch at %0t:", $realtime);
                        $display("  expected status=%0d slot=%0d gen=%h valid=%b word=%h fin=%b",
                                 want.status, want.new_slot, want.new_generation,
                                 want.handle_valid, want.user_value_out, want.finalize_request);
                        $display("  actual   status=%0d slot=%0d gen=%h valid=%b word=%h fin=%b",
                                 seen.status, seen.new_slot, seen.new_generation,
                                 seen.handle_valid, seen.user_value_out, seen.finalize_request);
                    end
                    bad_results++;
                end
            end
        end
    end

    initial
    begin
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        test_basic_operations();
        test_type_and_finalize();
        test_output_backpressure();
        test_random_traffic();
        settle_table();
        repeat (8) @(posedge clk);
        if (bad_results == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Safety net well beyond the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

FILE: generational_handle_table_top.f
src/ght_pkg.sv
src/ght_ram.sv
src/ght_seq.sv
src/ght_alu.sv
src/generational_handle_table_top.sv
src/ght_checker.sv
verif/tb_top.sv
